@@ rtl/ssbr_pkg.sv @@
package ssbr_pkg;

    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_NEAR = 2'd1;
    localparam logic [1:0] RRPV_LONG = 2'd2;

    localparam logic [9:0] SEL_MID = 10'd512;
    localparam logic [9:0] SEL_MAX = 10'd1023;

    localparam logic [47:0] STRIDE_ONE = 48'd64;
    localparam logic [47:0] STRIDE_TWO = 48'd128;

    localparam logic signed [3:0] SCORE_MAX = 4'sd7;
    localparam logic signed [3:0] SCORE_MIN = -4'sd8;

    localparam logic signed [3:0] THRESH_RESET = 4'sd6;
    localparam logic [6:0]        NEAR_RESET   = 7'd5;

    localparam int unsigned REG_THRESH = 0;
    localparam int unsigned REG_NEAR   = 1;

    typedef struct packed {
        logic        req_type;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [15:0] valid_mask;
        logic [47:0] phys_addr;
        logic [47:0] pc;
        logic        is_hit;
        logic [6:0]  random_percent;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       bypassed;
        logic [1:0] inserted_rrpv;
    } rsp_t;

endpackage

@@ rtl/ssbr_if.sv @@
interface ssbr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ship_stream_bypass_replacement.sv @@
// Each accepted word passes in order through dequeue, row read, counter read, execute
// and output; the output step waits while an earlier result is held and not yet taken.
// The back end takes a new word only after the last one has left the output step.
// A two-word queue lets the input side accept while the back end is busy.
// Reset: asynchronous, active low; a clearing pass over the larger of NUM_SETS and
// 2**SIG_BITS entries then sweeps rows and counters; the queue takes up to two words meanwhile.
module ship_stream_bypass_replacement
    import ssbr_pkg::*;
#(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_BITS    = 6,
    parameter int LEADER_SETS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    ssbr_if.sink        req,
    ssbr_if.source      rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic signed [3:0] thresh_reg;
    logic [6:0]        near_reg;
    logic              q_valid, q_pop;
    req_t              q_data;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            near_reg   <= NEAR_RESET;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_THRESH[0])
            begin
                thresh_reg <= pwdata[3:0];
            end
            else
            begin
                near_reg <= pwdata[6:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NEAR[0])
        begin
            prdata[6:0] = near_reg;
        end
        else
        begin
            prdata = {{28{thresh_reg[3]}}, thresh_reg};
        end
    end

    ssbr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    ssbr_back #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .SIG_BITS    (SIG_BITS),
        .LEADER_SETS (LEADER_SETS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .thresh   (thresh_reg),
        .near_pct (near_reg),
        .rsp      (rsp)
    );
endmodule

@@ rtl/ssbr_front.sv @@
module ssbr_front
    import ssbr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ssbr_if.sink   req,
    output logic   q_valid,
    output req_t   q_data,
    input  logic   q_pop
);
    // two-entry queue between front and back
    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

@@ rtl/ssbr_back.sv @@
module ssbr_back
    import ssbr_pkg::*;
#(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_BITS    = 6,
    parameter int LEADER_SETS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  req_t              q_data,
    output logic              q_pop,
    input  logic signed [3:0] thresh,
    input  logic [6:0]        near_pct,
    ssbr_if.source            rsp
);
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int SIG_N   = 1 << SIG_BITS;
    localparam int CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
    localparam int CLR_W   = $clog2(CLR_N) + 1;
    localparam int MASK_N  = (NUM_WAYS < 16) ? NUM_WAYS : 16;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // set rows and counters kept in memories; cleared by a sweep after reset
    logic [NUM_WAYS*2-1:0]        rrpv_mem [NUM_SETS];
    logic [NUM_WAYS*SIG_BITS-1:0] sig_mem  [NUM_SETS];
    logic [47:0]                  prev_mem [NUM_SETS];
    logic [3:0]                   score_mem[NUM_SETS];
    logic [1:0]                   ctr_mem  [SIG_N];

    logic [2:0]                   st_reg;
    logic [CLR_W-1:0]             clr_reg;
    logic [9:0]                   sel_reg;
    req_t                         cur_reg;
    rsp_t                         res_reg;
    rsp_t                         out_reg;
    logic                         out_valid_reg;
    logic [NUM_WAYS*2-1:0]        rrpv_rd_reg;
    logic [NUM_WAYS*SIG_BITS-1:0] sig_rd_reg;
    logic [47:0]                  prev_rd_reg;
    logic [3:0]                   score_rd_reg;
    logic [1:0]                   ctr_rd_reg;

    logic [SET_W-1:0]     set_idx;
    logic [WAY_W-1:0]     way_idx;
    logic [SIG_BITS-1:0]  sig;
    logic [47:0]          pcv;
    logic [NUM_WAYS-1:0]  inval;
    logic [NUM_WAYS-1:0]  at_top;
    logic [1:0]           top;
    logic [1:0]           add;
    logic [WAY_W-1:0]     first_inv;
    logic [WAY_W-1:0]     first_top;
    logic                 any_inv;
    logic [NUM_WAYS*2-1:0] aged;
    logic                 ship_lead, stream_lead, sig_pol, stream_pol;
    logic signed [3:0]    score_cur, score_new;
    logic                 stride_hit;
    logic [SIG_BITS-1:0]  hit_sig;
    logic [SIG_BITS-1:0]  ctr_addr;
    logic                 ctr_bump;
    logic [1:0]           ins;
    logic                 bypass;
    rsp_t                 res;

    assign set_idx = cur_reg.set_index[SET_W-1:0];
    assign way_idx = WAY_W'(cur_reg.way_index % NUM_WAYS);
    assign pcv     = cur_reg.pc ^ (cur_reg.pc >> 6) ^ (cur_reg.pc >> 12);
    assign sig     = pcv[SIG_BITS-1:0];

    always_comb
    begin
        inval     = '0;
        at_top    = '0;
        top       = 2'd0;
        first_inv = '0;
        first_top = '0;
        any_inv   = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (w < MASK_N)
            begin
                inval[w] = !cur_reg.valid_mask[w];
            end
            if (rrpv_rd_reg[2*w +: 2] > top)
            begin
                top = rrpv_rd_reg[2*w +: 2];
            end
        end
        add = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[2*w +: 2] = rrpv_rd_reg[2*w +: 2] + add;
            at_top[w]      = (aged[2*w +: 2] == RRPV_MAX);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (inval[w])
            begin
                first_inv = WAY_W'(w);
                any_inv   = 1'b1;
            end
            if (at_top[w])
            begin
                first_top = WAY_W'(w);
            end
        end
    end

    assign ship_lead   = (32'(set_idx) < 32'(LEADER_SETS));
    assign stream_lead = !ship_lead && (32'(set_idx) >= 32'(NUM_SETS / 2))
                         && (32'(set_idx) < 32'(NUM_SETS / 2 + LEADER_SETS));
    assign sig_pol     = ship_lead || (!stream_lead && (sel_reg < SEL_MID));
    assign stream_pol  = !sig_pol;

    assign score_cur  = $signed(score_rd_reg);
    assign stride_hit = (cur_reg.phys_addr > prev_rd_reg)
                        && ((cur_reg.phys_addr - prev_rd_reg == STRIDE_ONE)
                        || (cur_reg.phys_addr - prev_rd_reg == STRIDE_TWO));
    always_comb
    begin
        score_new = score_cur;
        if (prev_rd_reg != '0 && cur_reg.phys_addr != prev_rd_reg)
        begin
            if (stride_hit)
            begin
                if (score_cur < SCORE_MAX)
                begin
                    score_new = score_cur + 4'sd1;
                end
            end
            else if (score_cur > SCORE_MIN)
            begin
                score_new = score_cur - 4'sd1;
            end
        end
    end

    assign hit_sig  = sig_rd_reg[SIG_BITS*way_idx +: SIG_BITS];
    assign ctr_addr = cur_reg.is_hit ? hit_sig : sig;

    always_comb
    begin
        bypass = 1'b0;
        if (stream_pol && (score_new >= thresh))
        begin
            bypass = !any_inv;
            ins    = RRPV_MAX;
        end
        else if (sig_pol)
        begin
            if (ctr_rd_reg >= 2'd2)
            begin
                ins = 2'd0;
            end
            else if (ctr_rd_reg == 2'd1)
            begin
                ins = RRPV_NEAR;
            end
            else
            begin
                ins = RRPV_LONG;
            end
        end
        else
        begin
            ins = (cur_reg.random_percent < near_pct) ? RRPV_NEAR : RRPV_LONG;
        end
    end

    assign ctr_bump = (cur_reg.req_type == REQ_UPDATE) && (cur_reg.is_hit || !bypass)
                      && (ctr_rd_reg != 2'd3);

    always_comb
    begin
        res = '0;
        if (cur_reg.req_type == REQ_VICTIM)
        begin
            res.victim_way = 4'(any_inv ? first_inv : first_top);
        end
        else if (!cur_reg.is_hit)
        begin
            if (bypass)
            begin
                res.bypassed = 1'b1;
            end
            else
            begin
                res.inserted_rrpv = ins;
            end
        end
    end

    assign q_pop     = (st_reg == ST_IDLE) && q_valid;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_CLEAR)
        begin
            if (clr_reg < CLR_W'(NUM_SETS))
            begin
                rrpv_mem[clr_reg[SET_W-1:0]]  <= '1;
                sig_mem[clr_reg[SET_W-1:0]]   <= '0;
                prev_mem[clr_reg[SET_W-1:0]]  <= '0;
                score_mem[clr_reg[SET_W-1:0]] <= '0;
            end
            if (clr_reg < CLR_W'(SIG_N))
            begin
                ctr_mem[clr_reg[SIG_BITS-1:0]] <= 2'd1;
            end
        end
        else if (st_reg == ST_EXEC)
        begin
            if (cur_reg.req_type == REQ_VICTIM)
            begin
                if (!any_inv)
                begin
                    rrpv_mem[set_idx] <= aged;
                end
            end
            else
            begin
                prev_mem[set_idx]  <= cur_reg.phys_addr;
                score_mem[set_idx] <= score_new;
                if (ctr_bump)
                begin
                    ctr_mem[ctr_addr] <= ctr_rd_reg + 2'd1;
                end
                if (cur_reg.is_hit)
                begin
                    rrpv_mem[set_idx][2*way_idx +: 2] <= 2'd0;
                end
                else if (!bypass)
                begin
                    rrpv_mem[set_idx][2*way_idx +: 2] <= ins;
                    sig_mem[set_idx][SIG_BITS*way_idx +: SIG_BITS] <= sig;
                end
            end
        end
        if (st_reg == ST_READ)
        begin
            rrpv_rd_reg  <= rrpv_mem[set_idx];
            sig_rd_reg   <= sig_mem[set_idx];
            prev_rd_reg  <= prev_mem[set_idx];
            score_rd_reg <= score_mem[set_idx];
        end
        if (st_reg == ST_LOOK)
        begin
            ctr_rd_reg <= ctr_mem[ctr_addr];
        end
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_reg       <= '0;
            sel_reg       <= SEL_MID;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if ((st_reg == ST_OUT) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(CLR_N - 1))
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        st_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    st_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    st_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    res_reg <= res;
                    if ((cur_reg.req_type == REQ_UPDATE) && cur_reg.is_hit)
                    begin
                        if (ship_lead && sel_reg != SEL_MAX)
                        begin
                            sel_reg <= sel_reg + 10'd1;
                        end
                        else if (stream_lead && sel_reg != 10'd0)
                        begin
                            sel_reg <= sel_reg - 10'd1;
                        end
                    end
                    st_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
